// ----- sv/mwh_pkg.sv -----
// ----------------------------------------------------------------------------
// mwh_pkg
// Shared constants, types and helper functions for the word-wise
// MurmurHash3 block.
// ----------------------------------------------------------------------------
package mwh_pkg;

	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

	localparam logic [2:0] CHAR_BYTES_RESET = 3'd1;

	// Controller states, one-hot.
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL1 = 8'b0000_0010,
		ST_MUL2 = 8'b0000_0100,
		ST_MIXH = 8'b0000_1000,
		ST_LEN  = 8'b0001_0000,
		ST_FM1  = 8'b0010_0000,
		ST_FM2  = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	// Datapath step commands from the controller.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mixh;
		logic len;
		logic fm1;
		logic fm2;
		logic emit;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic last;
	} dp_sts_t;

	function automatic logic [31:0] rotl15(input logic [31:0] v);
		return {v[16:0], v[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] v);
		return {v[18:0], v[31:19]};
	endfunction

endpackage

// ----- sv/mwh_if.sv -----
// ----------------------------------------------------------------------------
// mwh_if
// Valid/ready channel interfaces of the hash block: input words, finished
// hashes and the configuration write channel.
// ----------------------------------------------------------------------------
interface mwh_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        last_word;
	logic        empty_string;

	modport source (output valid, output data_word, output last_word,
		output empty_string, input ready);
	modport sink (input valid, input data_word, input last_word,
		input empty_string, output ready);
endinterface

interface mwh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

interface mwh_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] char_bytes;

	modport source (output valid, output char_bytes, input ready);
	modport sink (input valid, input char_bytes, output ready);
endinterface

// ----- sv/murmur3_word_hash.sv -----
// ----------------------------------------------------------------------------
// murmur3_word_hash
// MurmurHash3 (x86, 32-bit) over a string delivered as packed 32-bit words.
// ----------------------------------------------------------------------------
// Words of a string arrive on in_ch, first character in the most significant
// bits, with last_word set on the final word; a transfer with empty_string set
// drops any string in progress and returns the seed (17 times char_bytes).
// Each word goes from its input transfer to the next input ready through two
// passes through the single shared 32x32 multiplier (word times c1, then the
// rotated product times c2) and a step that folds the key into the running
// hash. A last word then adds three passes on the same multiplier (length
// product and the two finalizer multiplies) and a step that loads the output
// register; an empty string goes straight from its transfer to that load. The
// finished hash waits in an output register, so the next word is taken while
// a result is still unread; only loading a second result stalls until the
// first one has been transferred. char_bytes is written on the cfg channel,
// which is always ready; write it only while no string is in progress and no
// hash is being computed.
// ----------------------------------------------------------------------------
module murmur3_word_hash (
	input  logic             clk,
	input  logic             arst_n,
	mwh_in_if.sink           in_ch,
	mwh_out_if.source        out_ch,
	mwh_cfg_if.sink          cfg
);

	mwh_pkg::cmd_t    cmd;
	mwh_pkg::dp_sts_t dp_sts;
	logic             cfg_we;

	// The single configuration register accepts a write on every cycle.
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	// Controller: steps the datapath through mixing and finalization and
	// tracks whether the output register holds an untaken hash.
	mwh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_empty  (in_ch.empty_string),
		.out_ready (out_ch.ready),
		.dp_sts    (dp_sts),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	// Datapath: running hash, word count, in-message flag, char_bytes and
	// the shared multiplier.
	mwh_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_char_bytes (cfg.char_bytes),
		.data_word      (in_ch.data_word),
		.last_word      (in_ch.last_word),
		.empty_string   (in_ch.empty_string),
		.dp_sts         (dp_sts),
		.hash_value     (out_ch.hash_value)
	);

endmodule

// ----- sv/mwh_ctrl.sv -----
// ----------------------------------------------------------------------------
// mwh_ctrl
// Sequencer for the hash datapath; also owns the output valid flag.
// ----------------------------------------------------------------------------
module mwh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_empty,
	input  logic             out_ready,
	input  mwh_pkg::dp_sts_t dp_sts,
	output logic             in_ready,
	output logic             out_valid,
	output mwh_pkg::cmd_t    cmd
);

	mwh_pkg::state_t state_q;
	mwh_pkg::state_t state_nxt;
	logic            out_valid_q;
	logic            slot_free;
	logic            in_fire;

	assign in_ready  = (state_q == mwh_pkg::ST_IDLE);
	assign in_fire   = in_ready && in_valid;
	assign out_valid = out_valid_q;
	// The output register can take a new hash when empty or drained this cycle.
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			mwh_pkg::ST_IDLE: begin
				if (in_fire) begin
					cmd.load  = 1'b1;
					state_nxt = in_empty ? mwh_pkg::ST_EMIT : mwh_pkg::ST_MUL1;
				end
			end
			mwh_pkg::ST_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = mwh_pkg::ST_MUL2;
			end
			mwh_pkg::ST_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = mwh_pkg::ST_MIXH;
			end
			mwh_pkg::ST_MIXH: begin
				cmd.mixh  = 1'b1;
				state_nxt = dp_sts.last ? mwh_pkg::ST_LEN : mwh_pkg::ST_IDLE;
			end
			mwh_pkg::ST_LEN: begin
				cmd.len   = 1'b1;
				state_nxt = mwh_pkg::ST_FM1;
			end
			mwh_pkg::ST_FM1: begin
				cmd.fm1   = 1'b1;
				state_nxt = mwh_pkg::ST_FM2;
			end
			mwh_pkg::ST_FM2: begin
				cmd.fm2   = 1'b1;
				state_nxt = mwh_pkg::ST_EMIT;
			end
			mwh_pkg::ST_EMIT: begin
				if (slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = mwh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mwh_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mwh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/mwh_dp.sv -----
// ----------------------------------------------------------------------------
// mwh_dp
// Hash datapath: running state, the character-size register and one shared
// 32x32 multiplier used for both word mixing and the finalizer.
// ----------------------------------------------------------------------------
module mwh_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mwh_pkg::cmd_t     cmd,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_char_bytes,
	input  logic [31:0]       data_word,
	input  logic              last_word,
	input  logic              empty_string,
	output mwh_pkg::dp_sts_t  dp_sts,
	output logic [31:0]       hash_value
);

	logic [2:0]  char_bytes_q;
	logic        in_message_q;
	logic        last_q;
	logic        empty_q;
	logic [31:0] hash_q;
	logic [31:0] count_q;
	logic [31:0] k_q;
	logic [31:0] out_q;

	logic [31:0] seed;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] product;
	logic [31:0] fin_t;
	logic [31:0] mix_r;
	logic [31:0] mix_h;

	// Seed is 17 times the character size.
	assign seed = {25'd0, char_bytes_q, 4'd0} + {29'd0, char_bytes_q};

	assign fin_t = hash_q ^ k_q;
	assign mix_r = mwh_pkg::rotl13(hash_q ^ k_q);
	assign mix_h = {mix_r[29:0], 2'b00} + mix_r + mwh_pkg::MIX_ADD;

	always_comb begin
		mul_a = k_q;
		mul_b = mwh_pkg::MIX_C1;
		case (1'b1)
			cmd.mul2: begin
				mul_a = mwh_pkg::rotl15(k_q);
				mul_b = mwh_pkg::MIX_C2;
			end
			cmd.len: begin
				mul_a = count_q;
				mul_b = {29'd0, char_bytes_q};
			end
			cmd.fm1: begin
				mul_a = fin_t ^ {16'd0, fin_t[31:16]};
				mul_b = mwh_pkg::FIN_M1;
			end
			cmd.fm2: begin
				mul_a = hash_q ^ {13'd0, hash_q[31:13]};
				mul_b = mwh_pkg::FIN_M2;
			end
			default: begin
				mul_a = k_q;
				mul_b = mwh_pkg::MIX_C1;
			end
		endcase
	end

	// Only the low word of each product is ever needed (arithmetic mod 2^32).
	assign product = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bytes_q <= mwh_pkg::CHAR_BYTES_RESET;
			in_message_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				char_bytes_q <= cfg_char_bytes;
			end
			if (cmd.load) begin
				in_message_q <= !empty_string && !last_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q  <= last_word;
			empty_q <= empty_string;
			k_q     <= data_word;
			if (empty_string || !in_message_q) begin
				hash_q <= seed;
			end
			count_q <= in_message_q ? count_q + 32'd1 : 32'd1;
		end
		if (cmd.mul1 || cmd.mul2 || cmd.len) begin
			k_q <= product[31:0];
		end
		if (cmd.mixh) begin
			hash_q <= mix_h;
		end
		if (cmd.fm1 || cmd.fm2) begin
			hash_q <= product[31:0];
		end
		if (cmd.emit) begin
			out_q <= empty_q ? hash_q : (hash_q ^ {16'd0, hash_q[31:16]});
		end
	end

	assign dp_sts.last = last_q;
	assign hash_value  = out_q;

endmodule
